// ===== sv/assert_macros.svh =====
// Assertion macros shared by the dimmer RTL.
// Expects clk, and rst_n for TCD_ASSERT, in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define TCD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define TCD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/tcd_pkg.sv =====
// Package for the two-channel encoder dimmer: constants, register indexes
// and the logarithmic duty table. No dependencies.
package tcd_pkg;

    localparam int TABLE_DEPTH_DEF    = 40;
    localparam int LED_COUNT_DEF      = 10;
    localparam int TICKS_PER_LED_DEF  = 16;
    localparam int TICKS_PER_STEP_DEF = 4;

    localparam int STORED_ENTRIES = 40;
    localparam logic [7:0]  WRAP_LIMIT        = 8'd200;
    localparam logic [7:0]  MAX_LEVEL_RESET   = 8'd160;
    localparam logic [15:0] FULL_ON_RESET     = 16'd51000;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_LEVEL    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_FULL_ON_DUTY = 1'b1;

    typedef logic signed [1:0] step_t;
    localparam step_t STEP_UP   = 2'sb01;
    localparam step_t STEP_DOWN = 2'sb11;
    localparam step_t STEP_NONE = 2'sb00;

    function automatic logic [15:0] log_duty(input logic [5:0] idx);
        logic [15:0] d;
        case (idx)
            6'd0:  d = 16'd0;
            6'd1:  d = 16'd2;
            6'd2:  d = 16'd8;
            6'd3:  d = 16'd14;
            6'd4:  d = 16'd21;
            6'd5:  d = 16'd29;
            6'd6:  d = 16'd38;
            6'd7:  d = 16'd48;
            6'd8:  d = 16'd59;
            6'd9:  d = 16'd72;
            6'd10: d = 16'd95;
            6'd11: d = 16'd115;
            6'd12: d = 16'd130;
            6'd13: d = 16'd145;
            6'd14: d = 16'd170;
            6'd15: d = 16'd190;
            6'd16: d = 16'd222;
            6'd17: d = 16'd255;
            6'd18: d = 16'd300;
            6'd19: d = 16'd350;
            6'd20: d = 16'd430;
            6'd21: d = 16'd530;
            6'd22: d = 16'd650;
            6'd23: d = 16'd783;
            6'd24: d = 16'd916;
            6'd25: d = 16'd1204;
            6'd26: d = 16'd1582;
            6'd27: d = 16'd2079;
            6'd28: d = 16'd2732;
            6'd29: d = 16'd3590;
            6'd30: d = 16'd4717;
            6'd31: d = 16'd6197;
            6'd32: d = 16'd8142;
            6'd33: d = 16'd10697;
            6'd34: d = 16'd14053;
            6'd35: d = 16'd18463;
            6'd36: d = 16'd24256;
            6'd37: d = 16'd31866;
            6'd38: d = 16'd40000;
            6'd39: d = 16'd49000;
            default: d = 16'd0;
        endcase
        return d;
    endfunction

endpackage

// ===== sv/tcd_level_eval.sv =====
// Level update of the selected channel: step add, wrap clear, clamp,
// duty lookup and bargraph count. Depends on tcd_pkg.
module tcd_level_eval
    import tcd_pkg::*;
#(
    parameter int TABLE_DEPTH    = TABLE_DEPTH_DEF,
    parameter int LED_COUNT      = LED_COUNT_DEF,
    parameter int TICKS_PER_LED  = TICKS_PER_LED_DEF,
    parameter int TICKS_PER_STEP = TICKS_PER_STEP_DEF
)
(
    input  logic [7:0]  level_cur,
    input  step_t       step,
    input  logic [7:0]  max_level,
    input  logic [15:0] full_on_duty,
    output logic [7:0]  level_new,
    output logic [15:0] duty,
    output logic [3:0]  bar
);

    // reciprocals scaled by 2^16, exact quotient for any 8-bit level
    localparam logic [16:0] STEP_RECIP =
        17'((65536 + TICKS_PER_STEP - 1) / TICKS_PER_STEP);
    localparam logic [16:0] LED_RECIP =
        17'((65536 + TICKS_PER_LED - 1) / TICKS_PER_LED);

    logic [7:0]  sum;
    logic [7:0]  unwrapped;
    logic [7:0]  idx;
    logic [7:0]  leds;
    logic [23:0] step_prod;
    logic [23:0] led_prod;

    always_comb
    begin
        sum       = level_cur + {{6{step[1]}}, step};
        unwrapped = (sum > WRAP_LIMIT) ? 8'd0 : sum;
        level_new = (unwrapped > max_level) ? max_level : unwrapped;

        step_prod = {16'd0, level_new} * {7'd0, STEP_RECIP};
        idx       = step_prod[23:16];
        if ({1'b0, idx} < 9'(TABLE_DEPTH) && {1'b0, idx} < 9'(STORED_ENTRIES))
        begin
            duty = log_duty(idx[5:0]);
        end
        else
        begin
            duty = full_on_duty;
        end

        led_prod = {16'd0, level_new} * {7'd0, LED_RECIP};
        leds     = led_prod[23:16];
        if (leds > 8'(LED_COUNT))
        begin
            leds = 8'(LED_COUNT);
        end
        bar = leds[3:0];
    end

endmodule

// ===== sv/two_channel_encoder_dimmer.sv =====
// Two-channel encoder dimmer, top level. An accepted input passes the input
// register, then the result register; one item per cycle while out_stall
// does not hold the result, as the state update between the two is combinational.
// Reset (rst_n, async low) clears both valid flags, button machine, channel,
// levels, duties and encoder state; max_level and full_on_duty go to 160, 51000.
// Depends on tcd_pkg, tcd_level_eval and assert_macros.svh.
`include "assert_macros.svh"

module two_channel_encoder_dimmer
    import tcd_pkg::*;
#(
    parameter int TABLE_DEPTH    = TABLE_DEPTH_DEF,
    parameter int LED_COUNT      = LED_COUNT_DEF,
    parameter int TICKS_PER_LED  = TICKS_PER_LED_DEF,
    parameter int TICKS_PER_STEP = TICKS_PER_STEP_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   phase_a_active,
    input  logic                   phase_b_active,
    input  logic                   button_down,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [15:0]            duty_first,
    output logic [15:0]            duty_second,
    output logic                   drive_first,
    output logic                   drive_second,
    output logic                   restart_counter,
    output logic [3:0]             bar_count,
    output logic                   selected_channel
);

    typedef enum logic [1:0] {
        BTN_RELEASED,
        BTN_PRESSED,
        BTN_HELD,
        BTN_RELEASING
    } btn_state_t;

    logic        in_valid_reg;
    logic        a_reg, b_reg, down_reg;
    logic        out_valid_reg;
    btn_state_t  btn_reg, btn_next;
    logic        chan_reg, chan_next;
    logic [7:0]  level_first_reg, level_first_next;
    logic [7:0]  level_second_reg, level_second_next;
    logic [15:0] duty_first_reg, duty_first_next;
    logic [15:0] duty_second_reg, duty_second_next;
    logic [1:0]  enc_last_reg, enc_last_next;
    step_t       step_reg, step_next;
    logic        restart_reg, restart_next;
    logic [3:0]  bar_reg;
    logic [7:0]  max_level_reg;
    logic [15:0] full_on_reg;

    logic        advance;
    logic        in_take;
    logic [7:0]  level_sel;
    logic [7:0]  level_upd;
    logic [15:0] duty_upd;
    logic [3:0]  bar_upd;
    logic [1:0]  enc_now;
    logic [1:0]  enc_diff;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    assign level_sel = chan_next ? level_second_reg : level_first_reg;

    tcd_level_eval #(
        .TABLE_DEPTH    (TABLE_DEPTH),
        .LED_COUNT      (LED_COUNT),
        .TICKS_PER_LED  (TICKS_PER_LED),
        .TICKS_PER_STEP (TICKS_PER_STEP)
    ) u_eval (
        .level_cur    (level_sel),
        .step         (step_reg),
        .max_level    (max_level_reg),
        .full_on_duty (full_on_reg),
        .level_new    (level_upd),
        .duty         (duty_upd),
        .bar          (bar_upd)
    );

    always_comb
    begin
        btn_next  = btn_reg;
        chan_next = chan_reg;
        case (btn_reg)
            BTN_RELEASED:
            begin
                if (down_reg)
                begin
                    btn_next  = BTN_PRESSED;
                    chan_next = !chan_reg;
                end
            end
            BTN_PRESSED:   if (down_reg)  btn_next = BTN_HELD;
            BTN_HELD:      if (!down_reg) btn_next = BTN_RELEASING;
            BTN_RELEASING: if (!down_reg) btn_next = BTN_RELEASED;
            default:       btn_next = BTN_RELEASED;
        endcase

        level_first_next  = level_first_reg;
        level_second_next = level_second_reg;
        duty_first_next   = duty_first_reg;
        duty_second_next  = duty_second_reg;
        if (chan_next)
        begin
            level_second_next = level_upd;
            duty_second_next  = duty_upd;
        end
        else
        begin
            level_first_next = level_upd;
            duty_first_next  = duty_upd;
        end

        // gray decode: phase pair -> quadrature position
        enc_now       = {a_reg, a_reg ^ b_reg};
        enc_diff      = enc_last_reg - enc_now;
        enc_last_next = enc_last_reg;
        step_next     = STEP_NONE;
        if (enc_diff[0])
        begin
            enc_last_next = enc_now;
            step_next     = enc_diff[1] ? STEP_UP : STEP_DOWN;
        end

        restart_next = (duty_first_next != 16'd0 && duty_first_reg == 16'd0) ||
                       (duty_second_next != 16'd0 && duty_second_reg == 16'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            btn_reg          <= BTN_RELEASED;
            chan_reg         <= 1'b0;
            level_first_reg  <= 8'd0;
            level_second_reg <= 8'd0;
            duty_first_reg   <= 16'd0;
            duty_second_reg  <= 16'd0;
            enc_last_reg     <= 2'd0;
            step_reg         <= STEP_NONE;
            max_level_reg    <= MAX_LEVEL_RESET;
            full_on_reg      <= FULL_ON_RESET;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            out_valid_reg <= advance || (out_valid_reg && out_stall);
            if (advance)
            begin
                btn_reg          <= btn_next;
                chan_reg         <= chan_next;
                level_first_reg  <= level_first_next;
                level_second_reg <= level_second_next;
                duty_first_reg   <= duty_first_next;
                duty_second_reg  <= duty_second_next;
                enc_last_reg     <= enc_last_next;
                step_reg         <= step_next;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MAX_LEVEL:    max_level_reg <= cfg_data[7:0];
                    REG_FULL_ON_DUTY: full_on_reg   <= cfg_data[15:0];
                    default:          ;
                endcase
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            a_reg    <= phase_a_active;
            b_reg    <= phase_b_active;
            down_reg <= button_down;
        end
        if (advance)
        begin
            restart_reg <= restart_next;
            bar_reg     <= bar_upd;
        end
    end

    assign out_valid        = out_valid_reg;
    assign duty_first       = duty_first_reg;
    assign duty_second      = duty_second_reg;
    assign drive_first      = |duty_first_reg;
    assign drive_second     = |duty_second_reg;
    assign restart_counter  = restart_reg;
    assign bar_count        = bar_reg;
    assign selected_channel = chan_reg;

    `TCD_ASSERT(a_level_bound,
        level_first_reg <= WRAP_LIMIT && level_second_reg <= WRAP_LIMIT,
        "level above wrap limit")
    `TCD_ASSERT(a_idle_chan_holds,
        advance && !chan_next |=> level_second_reg == $past(level_second_reg),
        "unselected level changed")
    `TCD_ASSERT(a_restart_lit,
        out_valid_reg && restart_reg |-> drive_first || drive_second,
        "restart with no channel lit")
    `TCD_ASSERT(a_toggle_on_press,
        chan_reg != $past(chan_reg) |->
            $past(advance && btn_reg == BTN_RELEASED && down_reg),
        "channel toggled without a new press")

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: self-checking testbench for two_channel_encoder_dimmer.
// Feeds encoder and button items in bursts against random output stalls and checks
// every result against a cycle-free dimmer model or a typed expectation. Needs tcd_pkg and the RTL.

module tb_top;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int MAX_REPORTS  = 10;
    localparam int LONG_HOLD    = 160;
    localparam int HOLD_AFTER   = 500;
    localparam int PIPE_LATENCY = 2;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int STEP_DIV     = 4;
    localparam int LED_DIV      = 16;
    localparam int BAR_MAX      = 10;
    localparam int CURVE_LEN    = 40;
    localparam logic [7:0] LEVEL_WRAP = 8'd200;

    // index 0 is the rightmost entry
    localparam logic [CURVE_LEN-1:0][15:0] DUTY_CURVE = {
        16'd49000, 16'd40000, 16'd31866, 16'd24256, 16'd18463, 16'd14053, 16'd10697,
        16'd8142, 16'd6197, 16'd4717, 16'd3590, 16'd2732, 16'd2079, 16'd1582, 16'd1204,
        16'd916, 16'd783, 16'd650, 16'd530, 16'd430, 16'd350, 16'd300, 16'd255, 16'd222,
        16'd190, 16'd170, 16'd145, 16'd130, 16'd115, 16'd95, 16'd72, 16'd59, 16'd48,
        16'd38, 16'd29, 16'd21, 16'd14, 16'd8, 16'd2, 16'd0};

    typedef enum logic [1:0] {BTN_RELEASED, BTN_PRESSED, BTN_HELD, BTN_LIFTED} btn_phase_t;
    typedef enum {SPIN_UP, SPIN_DOWN, PRESS, NOISE} stim_mode_t;
    typedef enum {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_TOGGLE} stall_pat_t;

    typedef struct packed {
        logic [15:0] duty0;
        logic [15:0] duty1;
        logic        drive0;
        logic        drive1;
        logic        restart;
        logic [3:0]  bar;
        logic        chan;
    } dim_result_t;

    typedef struct packed {
        logic        a;
        logic        b;
        logic        down;
        logic        typed;
        dim_result_t want;
    } dir_row_t;

    localparam dim_result_t ALL_DARK = '0;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_we;
    logic [tcd_pkg::CFG_INDEX_W-1:0]  cfg_index;
    logic [tcd_pkg::CFG_DATA_W-1:0]   cfg_data;
    logic                             in_valid;
    logic                             in_stall;
    logic                             phase_a_active;
    logic                             phase_b_active;
    logic                             button_down;
    logic                             out_valid;
    logic                             out_stall;
    logic [15:0]                      duty_first;
    logic [15:0]                      duty_second;
    logic                             drive_first;
    logic                             drive_second;
    logic                             restart_counter;
    logic [3:0]                       bar_count;
    logic                             selected_channel;

    // dimmer model state
    btn_phase_t  btn_state     = BTN_RELEASED;
    logic        chan_sel      = 1'b0;
    logic [7:0]  chan_level [2] = '{8'd0, 8'd0};
    logic [15:0] chan_duty [2]  = '{16'd0, 16'd0};
    logic [1:0]  enc_prev      = 2'd0;
    logic [7:0]  pending_steps = 8'd0;
    logic [7:0]  cfg_max       = 8'd160;
    logic [15:0] cfg_full      = 16'd51000;

    dim_result_t expected_q [$];
    logic        cur_typed = 1'b0;
    dim_result_t cur_want  = '0;
    logic [1:0]  enc_pos   = 2'd0;

    int n_accepted   = 0;
    int n_checked    = 0;
    int n_errors     = 0;
    int n_toggles    = 0;
    int n_full_on    = 0;
    int n_wraps      = 0;
    int n_in_stalls  = 0;
    int peak_level   = 0;
    int cycle_count  = 0;
    bit hold_done    = 1'b0;

    // a, b, button, typed, expected
    dir_row_t dir_rows [23] = '{
        {4'b0001, ALL_DARK},
        {4'b1001, ALL_DARK},
        {4'b1001, ALL_DARK},    // step below zero wraps and clears
        {4'b0000, ALL_DARK},
        {4'b0100, ALL_DARK},
        {4'b1100, ALL_DARK},
        {4'b1000, ALL_DARK},
        {4'b0000, ALL_DARK},
        {4'b0100, ALL_DARK},
        {4'b0110, ALL_DARK},
        {4'b1110, ALL_DARK},
        {4'b1110, ALL_DARK},
        {4'b1000, ALL_DARK},
        {4'b0000, ALL_DARK},
        {4'b0010, ALL_DARK},
        {4'b0000, ALL_DARK},    // release before second pressed sample
        {4'b1010, ALL_DARK},
        {4'b1000, ALL_DARK},
        {4'b1010, ALL_DARK},    // bounce during release
        {4'b0000, ALL_DARK},
        {4'b1100, ALL_DARK},    // two-step jump, no count
        {4'b0000, ALL_DARK},
        {4'b0100, ALL_DARK}
    };

    two_channel_encoder_dimmer uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .phase_a_active   (phase_a_active),
        .phase_b_active   (phase_b_active),
        .button_down      (button_down),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .duty_first       (duty_first),
        .duty_second      (duty_second),
        .drive_first      (drive_first),
        .drive_second     (drive_second),
        .restart_counter  (restart_counter),
        .bar_count        (bar_count),
        .selected_channel (selected_channel)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic dim_result_t dimmer_tick(input logic a, input logic b, input logic down);
        dim_result_t res;
        logic [15:0] prev0;
        logic [15:0] prev1;
        logic [7:0]  lvl;
        logic [1:0]  now;
        logic [1:0]  diff;
        int          idx;
        int          bar;
        prev0 = chan_duty[0];
        prev1 = chan_duty[1];
        case (btn_state)
            BTN_RELEASED:
            begin
                if (down)
                begin
                    btn_state = BTN_PRESSED;
                    chan_sel  = ~chan_sel;
                    n_toggles++;
                end
            end
            BTN_PRESSED:
            begin
                if (down)
                    btn_state = BTN_HELD;
            end
            BTN_HELD:
            begin
                if (!down)
                    btn_state = BTN_LIFTED;
            end
            default:
            begin
                if (!down)
                    btn_state = BTN_RELEASED;
            end
        endcase

        lvl = chan_level[chan_sel] + pending_steps;
        if (lvl > LEVEL_WRAP)
        begin
            lvl = 8'd0;
            n_wraps++;
        end
        if (lvl > cfg_max)
            lvl = cfg_max;
        chan_level[chan_sel] = lvl;
        if (int'(lvl) > peak_level)
            peak_level = int'(lvl);
        idx = int'(lvl) / STEP_DIV;
        if (idx < CURVE_LEN)
            chan_duty[chan_sel] = DUTY_CURVE[idx];
        else
        begin
            chan_duty[chan_sel] = cfg_full;
            n_full_on++;
        end
        pending_steps = 8'd0;
        bar = int'(lvl) / LED_DIV;
        if (bar > BAR_MAX)
            bar = BAR_MAX;

        // gray decode feeds the next tick
        now = a ? 2'd3 : 2'd0;
        if (b)
            now = now ^ 2'd1;
        diff = enc_prev - now;
        if (diff[0])
        begin
            enc_prev      = now;
            pending_steps = diff[1] ? 8'd1 : 8'hFF;
        end

        res.duty0   = chan_duty[0];
        res.duty1   = chan_duty[1];
        res.drive0  = chan_duty[0] != 16'd0;
        res.drive1  = chan_duty[1] != 16'd0;
        res.restart = (chan_duty[0] != 16'd0 && prev0 == 16'd0) ||
                      (chan_duty[1] != 16'd0 && prev1 == 16'd0);
        res.bar     = bar[3:0];
        res.chan    = chan_sel;
        return res;
    endfunction

    always @(posedge clk)
    begin
        dim_result_t got;
        dim_result_t want;
        dim_result_t model;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == tcd_pkg::REG_MAX_LEVEL)
                    cfg_max = cfg_data[7:0];
                else if (cfg_index == tcd_pkg::REG_FULL_ON_DUTY)
                    cfg_full = cfg_data;
            end
            if (out_valid && !out_stall)
            begin
                got = {duty_first, duty_second, drive_first, drive_second,
                       restart_counter, bar_count, selected_channel};
                if (expected_q.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("unexpected result with nothing pending: %h", got);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got !== want)
                    begin
                        n_errors++;
                        if (n_errors <= MAX_REPORTS)
                        begin
                            $display("result %0d exp: duty %0d/%0d drv %b%b rst %b bar %0d ch %b",
                                     n_checked, want.duty0, want.duty1, want.drive0,
                                     want.drive1, want.restart, want.bar, want.chan);
                            $display("result %0d got: duty %0d/%0d drv %b%b rst %b bar %0d ch %b",
                                     n_checked, got.duty0, got.duty1, got.drive0,
                                     got.drive1, got.restart, got.bar, got.chan);
                        end
                    end
                    n_checked++;
                end
            end
            if (in_valid && in_stall)
                n_in_stalls++;
            if (in_valid && !in_stall)
            begin
                model = dimmer_tick(phase_a_active, phase_b_active, button_down);
                expected_q.push_back(cur_typed ? cur_want : model);
                n_accepted++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     expected_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    // receiver: random stall stretches plus one long hold-off
    initial
    begin
        stall_pat_t pat;
        int         span;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!hold_done && n_accepted >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                repeat (LONG_HOLD)
                begin
                    @(negedge clk);
                    out_stall <= 1'b1;
                end
            end
            pat  = stall_pat_t'($urandom_range(0, 3));
            span = $urandom_range(4, 60);
            repeat (span)
            begin
                @(negedge clk);
                case (pat)
                    FLOW_FREE:   out_stall <= 1'b0;
                    FLOW_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
                    FLOW_HEAVY:  out_stall <= ($urandom_range(0, 4) != 0);
                    default:     out_stall <= ~out_stall;
                endcase
            end
        end
    end

    task automatic send_item(input logic a, input logic b, input logic down,
                             input logic typed, input dim_result_t want);
        @(negedge clk);
        in_valid       <= 1'b1;
        phase_a_active <= a;
        phase_b_active <= b;
        button_down    <= down;
        cur_typed = typed;
        cur_want  = want;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
    endtask

    task automatic pause_input(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    task automatic drain_results();
        pause_input(1);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 1) @(posedge clk);
    endtask

    task automatic write_config(input logic [7:0] max_lvl, input logic [15:0] full_duty);
        drain_results();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= tcd_pkg::REG_MAX_LEVEL;
        cfg_data  <= {8'd0, max_lvl};
        @(negedge clk);
        cfg_index <= tcd_pkg::REG_FULL_ON_DUTY;
        cfg_data  <= full_duty;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // mostly well-formed knob turns and presses, some raw noise
    task automatic run_random(input int count);
        stim_mode_t mode;
        int         run_left;
        int         up_len;
        int         burst_left;
        int         pick;
        logic       a;
        logic       b;
        logic       down;
        mode       = SPIN_UP;
        run_left   = 0;
        up_len     = 0;
        burst_left = $urandom_range(1, 40);
        for (int i = 0; i < count; i++)
        begin
            if (run_left == 0)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                begin
                    mode     = SPIN_UP;
                    run_left = $urandom_range(1, 120);
                end
                else if (pick < 8)
                begin
                    mode     = SPIN_DOWN;
                    run_left = $urandom_range(1, 60);
                end
                else if (pick < 9)
                begin
                    mode     = PRESS;
                    up_len   = $urandom_range(1, 3);
                    run_left = up_len + $urandom_range(1, 3);
                end
                else
                begin
                    mode     = NOISE;
                    run_left = $urandom_range(1, 8);
                end
            end
            down = 1'b0;
            case (mode)
                SPIN_UP:   enc_pos = enc_pos + 2'd1;
                SPIN_DOWN: enc_pos = enc_pos - 2'd1;
                PRESS:     down = (run_left > up_len);
                default:
                begin
                    down    = 1'($urandom_range(0, 1));
                    enc_pos = 2'($urandom_range(0, 3));
                end
            endcase
            a = enc_pos[1];
            b = enc_pos[1] ^ enc_pos[0];
            run_left--;
            send_item(a, b, down, 1'b0, ALL_DARK);
            burst_left--;
            if (burst_left == 0)
            begin
                if ($urandom_range(0, 9) < 7)
                    pause_input($urandom_range(1, 10));
                burst_left = $urandom_range(1, 40);
            end
        end
    endtask

    initial
    begin
        int waited;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = tcd_pkg::REG_MAX_LEVEL;
        cfg_data       = '0;
        in_valid       = 1'b0;
        phase_a_active = 1'b0;
        phase_b_active = 1'b0;
        button_down    = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_config(8'd160, 16'd51000);
        foreach (dir_rows[i])
            send_item(dir_rows[i].a, dir_rows[i].b, dir_rows[i].down,
                      dir_rows[i].typed, dir_rows[i].want);
        run_random(250);
        write_config(8'd200, 16'hFFFF);
        run_random(260);
        write_config(8'($urandom_range(1, 199)), 16'($urandom));
        run_random(260);
        write_config(8'd0, 16'd0);
        run_random(260);
        write_config(8'd200, 16'($urandom_range(0, 65535)));
        run_random(260);

        pause_input(1);
        waited = 0;
        while (expected_q.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_q.size() != 0)
        begin
            $display("%0d expected results never arrived", expected_q.size());
            n_errors += expected_q.size();
        end
        repeat (PIPE_LATENCY + 2) @(posedge clk);

        $display("run: %0d items, %0d results checked, %0d channel toggles, peak level %0d",
                 n_accepted, n_checked, n_toggles, peak_level);
        $display("run: %0d full-on duties, %0d level wraps, %0d input stalls, long hold %0s",
                 n_full_on, n_wraps, n_in_stalls, hold_done ? "done" : "missed");
        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/tcd_pkg.sv
sv/tcd_level_eval.sv
sv/two_channel_encoder_dimmer.sv
verif/tb_top.sv
